/* rtl/nsrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nsrc_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_STEP_FRAC     = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_SAMPLE_WIDTH  = 2'd2;
   localparam logic [1:0] REG_OUT_FRAMES    = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam int STEP_W      = 12;
   localparam int FRAC_W      = 8;
   localparam int FRAMES_W    = 24;
   localparam int SAMPLE_W    = 16;

   localparam logic [STEP_W-1:0] STEP_RESET = 12'd256;
   localparam logic [1:0]        CHAN_RESET = 2'd1;

   // sample_width codes
   localparam logic WIDTH_8_UNSIGNED  = 1'b0;
   localparam logic WIDTH_16_SIGNED   = 1'b1;

   // results produced per input word at most
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel;
      logic                       chunk_start;
      logic                       sound_done;
   } result_type;

   function automatic logic [SAMPLE_W-1:0] convert(input logic [SAMPLE_W-1:0] raw,
                                                   input logic width_sel);
      logic [SAMPLE_W-1:0] res;
      if (width_sel == WIDTH_8_UNSIGNED) begin
         res = {~raw[7], raw[6:0], 8'h00};
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/nearest_sample_rate_converter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor sample rate converter. Interleaved source samples enter on
// the req channel one word at a time; for each one the block emits the resampled
// signed 16-bit output samples that this word makes available (0 to 16 words on
// the rsp channel, the final one flagged by rsp_run_last). Output frame i reads
// source index floor(sum of step_frac / 256) plus its channel; 8-bit input is
// re-centered and shifted into the upper byte. One shared index/age datapath
// produces one output sample per cycle while the rsp side keeps up; the small
// sequencer goes from idle to eval on each accepted word and back to idle once
// its last held result has gone to the output register. req_ready is high
// only between words; the last result may still wait in the output register.
// Program the csr registers while idle. Production stops after out_frames
// frames; a new sound needs a reset.
module nearest_sample_rate_converter_unit
   import nsrc_pkg::*;
#(
   parameter int CHUNK_SIZE   = 1024,
   parameter int WINDOW_DEPTH = 4,
   parameter int COUNT_WIDTH  = 24
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [SAMPLE_W-1:0]          req_sample_raw,
   input  wire                          req_last_in,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_channel_index,
   output logic                         rsp_chunk_start,
   output logic                         rsp_run_last,
   output logic                         rsp_sound_done,
   input  wire                          csr_wr_en,
   input  wire  [CSR_INDEX_W-1:0]       csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int CPW   = $clog2(CHUNK_SIZE);
   localparam int IW    = $clog2(WINDOW_DEPTH);
   localparam int CMP_W = ((COUNT_WIDTH > FRAMES_W) ? COUNT_WIDTH : FRAMES_W) + 1;

   // configuration
   logic [STEP_W-1:0]   step_frac_ff;
   logic [1:0]          channel_count_ff;
   logic                sample_width_ff;
   logic [FRAMES_W-1:0] out_frames_ff;

   // sequencer state
   state_type           state_ff, state_in;
   logic [NRES_W-1:0]   nres_ff, nres_in;
   logic [FRAC_W-1:0]   frac_acc_ff, frac_acc_in;
   logic [COUNT_WIDTH-1:0] src_index_ff, src_index_in;
   logic [COUNT_WIDTH-1:0] frame_cnt_ff, frame_cnt_in;
   logic                chan_cnt_ff, chan_cnt_in;
   logic [COUNT_WIDTH-1:0] input_cnt_ff, input_cnt_in;
   logic [CPW-1:0]      chunk_pos_ff, chunk_pos_in;
   logic                ended_ff, ended_in;
   logic [SAMPLE_W-1:0] window_ff [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] window_in [WINDOW_DEPTH];

   // result waiting to learn whether it closes the run
   result_type          hold_ff, hold_in;
   logic                hold_vld_ff, hold_vld_in;
   result_type          out_ff, out_in;
   logic                out_last_ff, out_last_in;
   logic                out_vld_ff, out_vld_in;

   // shared index datapath
   logic                two_ch;
   logic                chan;
   logic [COUNT_WIDTH-1:0] newest, need, age;
   logic                not_yet;
   logic [IW-1:0]       age_idx;
   logic [CMP_W-1:0]    frame_ext, frames_ext;
   logic                frame_lt, frame_final;
   logic                can_emit;
   logic                out_free;
   logic [STEP_W:0]     acc_full;
   logic                accept;
   result_type          cur;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !out_vld_ff || rsp_ready;

   assign two_ch  = channel_count_ff[1];
   assign chan    = two_ch ? chan_cnt_ff : 1'b0;
   assign newest  = input_cnt_ff - COUNT_WIDTH'(1);
   assign need    = src_index_ff + COUNT_WIDTH'(chan);
   assign age     = newest - need;
   assign not_yet = age[COUNT_WIDTH-1];

   always_comb begin
      if (not_yet) begin
         age_idx = '0;
      end else if (age >= COUNT_WIDTH'(WINDOW_DEPTH)) begin
         age_idx = IW'(WINDOW_DEPTH - 1);
      end else begin
         age_idx = age[IW-1:0];
      end
   end

   assign frame_ext   = CMP_W'(frame_cnt_ff);
   assign frames_ext  = CMP_W'(out_frames_ff);
   assign frame_lt    = frame_ext < frames_ext;
   assign frame_final = (frame_ext + CMP_W'(1)) == frames_ext;
   assign can_emit    = (nres_ff != NRES_W'(MAX_RESULTS)) && frame_lt && !(not_yet && !ended_ff);

   assign cur.sample      = convert(window_ff[age_idx], sample_width_ff);
   assign cur.channel     = chan;
   assign cur.chunk_start = (chunk_pos_ff == '0);
   assign cur.sound_done  = frame_final && (!two_ch || chan);

   // full accumulator add, only the integer part moves the source index
   assign acc_full = {{(STEP_W-FRAC_W+1){1'b0}}, frac_acc_ff} + {1'b0, step_frac_ff};

   always_comb begin
      state_in     = state_ff;
      nres_in      = nres_ff;
      frac_acc_in  = frac_acc_ff;
      src_index_in = src_index_ff;
      frame_cnt_in = frame_cnt_ff;
      chan_cnt_in  = chan_cnt_ff;
      input_cnt_in = input_cnt_ff;
      chunk_pos_in = chunk_pos_ff;
      ended_in     = ended_ff;
      window_in    = window_ff;
      hold_in      = hold_ff;
      hold_vld_in  = hold_vld_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               nres_in  = '0;
               state_in = ST_EVAL;
               if (!ended_ff) begin
                  for (int i = 1; i < WINDOW_DEPTH; i++) begin
                     window_in[i] = window_ff[i-1];
                  end
                  window_in[0] = req_sample_raw;
                  input_cnt_in = input_cnt_ff + COUNT_WIDTH'(1);
                  ended_in     = req_last_in;
               end
            end
         end
         ST_EVAL: begin
            if (can_emit) begin
               if (!hold_vld_ff || out_free) begin
                  if (hold_vld_ff) begin
                     out_in      = hold_ff;
                     out_last_in = 1'b0;
                     out_vld_in  = 1'b1;
                  end
                  hold_in     = cur;
                  hold_vld_in = 1'b1;
                  nres_in     = nres_ff + NRES_W'(1);
                  chunk_pos_in = (chunk_pos_ff == CPW'(CHUNK_SIZE - 1)) ? '0
                                 : chunk_pos_ff + CPW'(1);
                  if (two_ch && !chan) begin
                     chan_cnt_in = 1'b1;
                  end else begin
                     chan_cnt_in  = 1'b0;
                     frame_cnt_in = frame_cnt_ff + COUNT_WIDTH'(1);
                     src_index_in = src_index_ff + COUNT_WIDTH'(acc_full[STEP_W:FRAC_W]);
                     frac_acc_in  = acc_full[FRAC_W-1:0];
                  end
               end
            end else if (hold_vld_ff) begin
               if (out_free) begin
                  out_in      = hold_ff;
                  out_last_in = 1'b1;
                  out_vld_in  = 1'b1;
                  hold_vld_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_frac_ff     <= STEP_RESET;
         channel_count_ff <= CHAN_RESET;
         sample_width_ff  <= WIDTH_16_SIGNED;
         out_frames_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_STEP_FRAC:     step_frac_ff     <= csr_wr_data[STEP_W-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wr_data[1:0];
            REG_SAMPLE_WIDTH:  sample_width_ff  <= csr_wr_data[0];
            REG_OUT_FRAMES:    out_frames_ff    <= csr_wr_data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nres_ff      <= '0;
         frac_acc_ff  <= '0;
         src_index_ff <= '0;
         frame_cnt_ff <= '0;
         chan_cnt_ff  <= 1'b0;
         input_cnt_ff <= '0;
         chunk_pos_ff <= '0;
         ended_ff     <= 1'b0;
         hold_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         nres_ff      <= nres_in;
         frac_acc_ff  <= frac_acc_in;
         src_index_ff <= src_index_in;
         frame_cnt_ff <= frame_cnt_in;
         chan_cnt_ff  <= chan_cnt_in;
         input_cnt_ff <= input_cnt_in;
         chunk_pos_ff <= chunk_pos_in;
         ended_ff     <= ended_in;
         hold_vld_ff  <= hold_vld_in;
         out_vld_ff   <= out_vld_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_sample_out    = out_ff.sample;
   assign rsp_channel_index = out_ff.channel;
   assign rsp_chunk_start   = out_ff.chunk_start;
   assign rsp_sound_done    = out_ff.sound_done;
   assign rsp_run_last      = out_last_ff;

endmodule

`default_nettype wire

/* rtl/nsrc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nsrc_checker
   import nsrc_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [SAMPLE_W-1:0]  rsp_sample_out,
   input wire                 rsp_run_last,
   input wire                 rsp_sound_done
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_run_last))
      else $error("rsp word changed while stalled");

   // nothing is shown right after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // more results of the current word pending: no new input taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready)
      else $error("input taken before the run ended");

   // the final sample of a sound closes its run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sound_done |-> rsp_run_last)
      else $error("sound_done without run_last");

endmodule

bind nearest_sample_rate_converter_unit nsrc_checker u_nsrc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_run_last   (rsp_run_last),
   .rsp_sound_done (rsp_sound_done)
);

`default_nettype wire
